@@ src/rtd_pkg.sv @@
`timescale 1ns / 1ps

package rtd_pkg;

  localparam int RSSI_W  = 8;
  localparam int MAG_W   = 10;  // |num2| <= 638, in half-dB
  localparam int DIV_W   = 8;   // divisor 2 * tenths, at most 254
  localparam int TENTH_W = 7;
  localparam int K_W     = 6;   // integer part of the exponent, -27 .. 26
  localparam int M_W     = 31;  // mantissa in Q30, always below 2.0
  localparam int Q30     = 30;
  localparam int DIST_W  = 16;
  localparam int HUND_W  = 7;

  localparam logic [31:0]        LOG2_10_Q30 = 32'd3566893132;
  localparam logic [M_W-1:0]     ONE_Q30     = 31'h4000_0000;
  localparam logic [HUND_W-1:0]  CM_PER_M    = 7'd100;
  localparam logic [DIST_W-1:0]  DIST_MAX    = 16'hFFFF;
  localparam logic signed [K_W-1:0] K_SAT    = 6'sd10;
  localparam logic signed [K_W-1:0] K_TINY   = -6'sd8;

  localparam logic [7:0]         RSSI_OFFSET_RST = 8'd71;
  localparam logic [7:0]         REF_LOSS_RST    = 8'd45;
  localparam logic [TENTH_W-1:0] PLE_TENTHS_RST  = 7'd40;

  typedef enum logic [1:0] {
    REG_RSSI_OFFSET = 2'd0,
    REG_REF_LOSS    = 2'd1,
    REG_PLE_TENTHS  = 2'd2
  } cfg_idx_t;

  // round(2^(2^-(idx+1)) * 2^30)
  function automatic logic [M_W-1:0] pow2_frac(input logic [4:0] idx);
    logic [M_W-1:0] t;
    case (idx)
      5'd0:    t = 31'd1518500250;
      5'd1:    t = 31'd1276901417;
      5'd2:    t = 31'd1170923762;
      5'd3:    t = 31'd1121280436;
      5'd4:    t = 31'd1097253708;
      5'd5:    t = 31'd1085434106;
      5'd6:    t = 31'd1079572136;
      5'd7:    t = 31'd1076653033;
      5'd8:    t = 31'd1075197443;
      5'd9:    t = 31'd1074468888;
      5'd10:   t = 31'd1074105294;
      5'd11:   t = 31'd1073923544;
      5'd12:   t = 31'd1073832680;
      5'd13:   t = 31'd1073787251;
      5'd14:   t = 31'd1073764537;
      5'd15:   t = 31'd1073753181;
      5'd16:   t = 31'd1073747502;
      5'd17:   t = 31'd1073744663;
      5'd18:   t = 31'd1073743244;
      5'd19:   t = 31'd1073742534;
      5'd20:   t = 31'd1073742179;
      5'd21:   t = 31'd1073742001;
      5'd22:   t = 31'd1073741913;
      5'd23:   t = 31'd1073741868;
      default: t = ONE_Q30;
    endcase
    return t;
  endfunction

endpackage

@@ src/rtd_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage: ({mag, F zeros}) / divisor.
module rtd_div import rtd_pkg::*; #(
  parameter int F = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [MAG_W-1:0]       mag,
  input  logic                   neg,
  input  logic [DIV_W-1:0]       divisor,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [F+MAG_W-2:0]     quo,
  output logic                   rem_nz,
  output logic                   neg_q
);

  localparam int N = F + MAG_W - 1;

  logic           v      [N];
  logic           en     [N];
  logic [DIV_W-1:0] rem  [N];
  logic [N-1:0]   qd     [N];
  logic           ng     [N];

  logic           v_in   [N];
  logic [DIV_W-1:0] rem_in [N];
  logic [N-1:0]   qd_in  [N];
  logic           ng_in  [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      logic [DIV_W:0]   t;
      logic             ge;
      logic [DIV_W-1:0] rem_step;
      logic [N-1:0]     qd_step;

      if (i == 0) begin : g_first
        assign v_in[i]   = in_valid;
        assign rem_in[i] = DIV_W'(mag[MAG_W-1]);
        assign qd_in[i]  = {mag[MAG_W-2:0], {F{1'b0}}};
        assign ng_in[i]  = neg;
      end else begin : g_next
        assign v_in[i]   = v[i-1];
        assign rem_in[i] = rem[i-1];
        assign qd_in[i]  = qd[i-1];
        assign ng_in[i]  = ng[i-1];
      end

      if (i == N - 1) begin : g_last_en
        assign en[i] = !v[i] || out_ready;
      end else begin : g_mid_en
        assign en[i] = !v[i] || en[i+1];
      end

      // remainder stays below divisor, so the trial value fits in DIV_W+1 bits
      always_comb begin
        t        = {rem_in[i], qd_in[i][N-1]};
        ge       = t >= {1'b0, divisor};
        rem_step = ge ? DIV_W'(t - {1'b0, divisor}) : t[DIV_W-1:0];
        qd_step  = {qd_in[i][N-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (en[i]) begin
          v[i] <= v_in[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en[i] && v_in[i]) begin
          rem[i] <= rem_step;
          qd[i]  <= qd_step;
          ng[i]  <= ng_in[i];
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v[N-1];
  assign quo       = qd[N-1];
  assign rem_nz    = |rem[N-1];
  assign neg_q     = ng[N-1];

endmodule

@@ src/rtd_pow2.sv @@
`timescale 1ns / 1ps

// 2^fraction in Q30: one table multiply per fraction bit, MSB first.
module rtd_pow2 import rtd_pkg::*; #(
  parameter int F = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [F-1:0]   frac,
  input  logic [K_W-1:0] k_in,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [M_W-1:0] mant,
  output logic [K_W-1:0] k_out
);

  logic           v     [F];
  logic           en    [F];
  logic [M_W-1:0] m     [F];
  logic [F-1:0]   fr    [F];
  logic [K_W-1:0] k     [F];

  logic           v_in  [F];
  logic [M_W-1:0] m_in  [F];
  logic [F-1:0]   fr_in [F];
  logic [K_W-1:0] k_in_s [F];

  genvar j;
  generate
    for (j = 0; j < F; j++) begin : g_stage
      logic [2*M_W-1:0] prod;
      logic [M_W-1:0]   m_step;

      if (j == 0) begin : g_first
        assign v_in[j]   = in_valid;
        assign m_in[j]   = ONE_Q30;
        assign fr_in[j]  = frac;
        assign k_in_s[j] = k_in;
      end else begin : g_next
        assign v_in[j]   = v[j-1];
        assign m_in[j]   = m[j-1];
        assign fr_in[j]  = fr[j-1];
        assign k_in_s[j] = k[j-1];
      end

      if (j == F - 1) begin : g_last_en
        assign en[j] = !v[j] || out_ready;
      end else begin : g_mid_en
        assign en[j] = !v[j] || en[j+1];
      end

      always_comb begin
        prod   = m_in[j] * pow2_frac(5'(j));
        m_step = fr_in[j][F-1-j] ? prod[Q30+M_W-1:Q30] : m_in[j];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[j] <= 1'b0;
        end else if (en[j]) begin
          v[j] <= v_in[j];
        end
      end

      always_ff @(posedge clk) begin
        if (en[j] && v_in[j]) begin
          m[j]  <= m_step;
          fr[j] <= fr_in[j];
          k[j]  <= k_in_s[j];
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v[F-1];
  assign mant      = m[F-1];
  assign k_out     = k[F-1];

endmodule

@@ src/rssi_to_distance.sv @@
`timescale 1ns / 1ps

// RSSI to distance (log-distance path loss). Each item is one raw RSSI byte
// (two's complement, half-dB); the result is 10^((-dBm - ref) / (10 n)) m
// in cm, truncated, clamped to 65535 with the saturated flag set. The block
// takes one item per clock while the output is not stalled and holds up to
// 2*EXP_FRAC_BITS + 14 items in flight, most of them in the divider (one
// quotient bit per stage, EXP_FRAC_BITS + 9 stages) and the power-of-two
// unit (one table multiply per fraction bit). Stages advance independently,
// so bubbles close up while the output is stalled. Configuration writes take
// effect at once and must be made while empty.
module rssi_to_distance import rtd_pkg::*; #(
  parameter int EXP_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RSSI_W-1:0] rssi_reg,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] distance_cm,
  output logic              saturated
);

  localparam int F   = EXP_FRAC_BITS;
  localparam int QW  = F + MAG_W - 1;
  localparam int XW  = F + 5;
  localparam int PW  = XW + 33;
  localparam int PCW = Q30 + F + K_W;
  localparam int HW  = M_W + HUND_W;
  localparam logic [QW-1:0] XLIM = QW'(1) << (F + 3);

  // configuration
  logic [7:0]         rssi_offset_db;
  logic [7:0]         reference_loss_db;
  logic [TENTH_W-1:0] path_loss_exponent_tenths;
  logic [DIV_W-1:0]   divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      rssi_offset_db            <= RSSI_OFFSET_RST;
      reference_loss_db         <= REF_LOSS_RST;
      path_loss_exponent_tenths <= PLE_TENTHS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_RSSI_OFFSET: rssi_offset_db            <= cfg_data;
        REG_REF_LOSS:    reference_loss_db         <= cfg_data;
        REG_PLE_TENTHS:  path_loss_exponent_tenths <= cfg_data[TENTH_W-1:0];
        default: ;
      endcase
    end
  end

  // zero exponent reads as one tenth
  assign divisor = (path_loss_exponent_tenths == '0) ? DIV_W'(2)
                                                     : {path_loss_exponent_tenths, 1'b0};

  // handshake enables, back to front
  logic en_a, en_b, en_c, en_d, en_e;
  logic div_in_ready, div_out_valid, pow_in_ready, pow_out_valid;

  // stage A: numerator in half-dB, split into sign and magnitude
  logic             va;
  logic [MAG_W-1:0] a_mag;
  logic             a_neg;
  logic [MAG_W:0]   num2;

  assign num2 = {2'b00, rssi_offset_db, 1'b0}
              - {{3{rssi_reg[RSSI_W-1]}}, rssi_reg}
              - {2'b00, reference_loss_db, 1'b0};
  assign en_a     = !va || div_in_ready;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_neg <= num2[MAG_W];
      a_mag <= num2[MAG_W] ? MAG_W'(-num2) : num2[MAG_W-1:0];
    end
  end

  logic [QW-1:0] d_quo;
  logic          d_rem_nz, d_neg;

  rtd_div #(.F(F)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (va),
    .in_ready  (div_in_ready),
    .mag       (a_mag),
    .neg       (a_neg),
    .divisor   (divisor),
    .out_valid (div_out_valid),
    .out_ready (en_b),
    .quo       (d_quo),
    .rem_nz    (d_rem_nz),
    .neg_q     (d_neg)
  );

  // stage B: floor for negative numerators, clamp to +/-8, signed exponent
  logic          vb;
  logic [XW-1:0] xq;
  logic [QW-1:0] mag_fl, mag_cl;
  logic [XW-1:0] x_abs;

  assign en_b   = !vb || en_c;
  assign mag_fl = d_quo + QW'(d_neg && d_rem_nz);
  assign mag_cl = (mag_fl > XLIM) ? XLIM : mag_fl;
  assign x_abs  = {1'b0, mag_cl[F+3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en_b) begin
      vb <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && div_out_valid) begin
      xq <= d_neg ? -x_abs : x_abs;
    end
  end

  // stage C: times log2(10) in Q30; upper bits give the base-2 exponent
  logic                 vc;
  logic signed [PW-1:0] prod_l;
  logic [PCW-1:0]       pc;

  assign en_c   = !vc || pow_in_ready;
  assign prod_l = $signed(xq) * $signed({1'b0, LOG2_10_Q30});

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en_c) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && vb) begin
      pc <= prod_l[PCW-1:0];
    end
  end

  logic [M_W-1:0] p_mant;
  logic [K_W-1:0] p_k;

  rtd_pow2 #(.F(F)) u_pow2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vc),
    .in_ready  (pow_in_ready),
    .frac      (pc[Q30+F-1:Q30]),
    .k_in      (pc[PCW-1:Q30+F]),
    .out_valid (pow_out_valid),
    .out_ready (en_d),
    .mant      (p_mant),
    .k_out     (p_k)
  );

  // stage D: mantissa times 100
  logic           vd;
  logic [HW-1:0]  d_cm;
  logic [K_W-1:0] d_k;

  assign en_d = !vd || en_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en_d) begin
      vd <= pow_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && pow_out_valid) begin
      d_cm <= {HUND_W'(0), p_mant} * {M_W'(0), CM_PER_M};
      d_k  <= p_k;
    end
  end

  // stage E: scale by 2^k, saturate or flush to zero; output register
  logic [K_W-1:0]    shamt;
  logic [HW-1:0]     scaled;
  logic              big, tiny, over;
  logic [DIST_W-1:0] dist_next;
  logic              sat_next;

  assign en_e = !out_valid || out_ready;

  always_comb begin
    shamt  = K_W'(Q30) - d_k;
    scaled = d_cm >> shamt;
    big    = $signed(d_k) >= K_SAT;
    tiny   = $signed(d_k) <= K_TINY;
    over   = |scaled[HW-1:DIST_W];
    if (big || (!tiny && over)) begin
      dist_next = DIST_MAX;
      sat_next  = 1'b1;
    end else if (tiny) begin
      dist_next = '0;
      sat_next  = 1'b0;
    end else begin
      dist_next = scaled[DIST_W-1:0];
      sat_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_e) begin
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e && vd) begin
      distance_cm <= dist_next;
      saturated   <= sat_next;
    end
  end

endmodule

@@ src/rtd_checker.sv @@
`timescale 1ns / 1ps

module rtd_checker import rtd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] distance_cm,
  input logic              saturated
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance_cm) && $stable(saturated))
    else $error("result changed while stalled");

  // clamped results always read full scale
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> distance_cm == DIST_MAX)
    else $error("saturated result not at full scale");

  // a draining output never blocks the input
  a_ready_pass: assert property (@(posedge clk)
    out_ready |-> in_ready)
    else $error("input blocked while output ready");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind rssi_to_distance rtd_checker u_rtd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .distance_cm (distance_cm),
  .saturated   (saturated)
);
